>>> hdl/mlo_pkg.sv
`default_nettype none

package mlo_pkg;

   // Word and field widths
   localparam int REQ_W      = 32;
   localparam int RSP_W      = 80;
   localparam int POS_W      = 16;
   localparam int DELTA_W    = POS_W + 1;
   localparam int SENS_W     = 16;
   localparam int PLIM_W     = 14;
   localparam int ACC_W      = 24;
   localparam int PROD_W     = DELTA_W + SENS_W;
   localparam int Q14_W      = 16;
   localparam int BLEND_W    = 2 * Q14_W;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // Rotation unit: Q2.30 datapath with two guard bits, up to 24 steps
   localparam int CORDIC_STEPS = 16;
   localparam int IT_W         = 5;
   localparam int CW           = 34;
   localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);
   localparam int ONE_Q14      = 16384;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_SENS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PLIM = CSR_IDX_W'(1);
   localparam logic [SENS_W-1:0]    SENS_RESET = SENS_W'(4660);
   localparam logic [PLIM_W-1:0]    PLIM_RESET = PLIM_W'(16202);
   localparam logic [ACC_W-1:0]     YAW_RESET  = 24'hC00000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ACCUM,
      ST_CLAMP,
      ST_ROT_YAW,
      ST_SAVE_YAW,
      ST_ROT_PITCH,
      ST_SAVE_PITCH,
      ST_BLEND,
      ST_DONE
   } state_type;

   // Arctangent of 2^-i, 2^32 per turn
   function automatic logic [31:0] atan_lut(input logic [IT_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2E;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2F9;
         5'd15:   r = 32'h0000517C;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A2F;
         5'd19:   r = 32'h00000517;
         5'd20:   r = 32'h0000028B;
         5'd21:   r = 32'h00000145;
         5'd22:   r = 32'h000000A2;
         5'd23:   r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // Fold an accumulator angle into [-90, 90) degrees; top bit flags the fold
   function automatic logic [CW:0] fold_angle(input logic [ACC_W-1:0] acc);
      logic        flip;
      logic [31:0] ang;
      flip = acc[ACC_W-1] ^ acc[ACC_W-2];
      ang  = {acc[ACC_W-1] ^ flip, acc[ACC_W-2:0], 8'h00};
      return {flip, CW'(signed'(ang))};
   endfunction

   // Round Q2.30 to Q1.14, negating first when folded, then saturate
   function automatic logic [Q14_W-1:0] round_q30(input logic signed [CW-1:0] v,
                                                  input logic flip);
      logic signed [CW-1:0] t;
      logic signed [CW-1:0] s;
      logic signed [CW-1:0] r;
      t = (flip ? -v : v) + CW'(32768);
      s = t >>> 16;
      if (s > CW'(ONE_Q14))
         r = CW'(ONE_Q14);
      else if (s < -CW'(ONE_Q14))
         r = -CW'(ONE_Q14);
      else
         r = s;
      return r[Q14_W-1:0];
   endfunction

   // Round a Q2.28 product to Q1.14 and saturate
   function automatic logic [Q14_W-1:0] round_q28(input logic signed [BLEND_W-1:0] v);
      logic signed [BLEND_W-1:0] t;
      logic signed [BLEND_W-1:0] s;
      logic signed [BLEND_W-1:0] r;
      t = v + BLEND_W'(8192);
      s = t >>> 14;
      if (s > BLEND_W'(ONE_Q14))
         r = BLEND_W'(ONE_Q14);
      else if (s < -BLEND_W'(ONE_Q14))
         r = -BLEND_W'(ONE_Q14);
      else
         r = s;
      return r[Q14_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/mouse_look_orientation.sv
`default_nettype none

// Channel  Direction  Words                       Payload
// req      in         one cursor position         tdata: x_pos[15:0], y_pos[31:16]
// rsp      out        one view direction          tdata: front_x, front_y, front_z,
//                                                 yaw_angle, pitch_angle (16 bits each)
// csr      in         one register write          index 0 sensitivity, 1 pitch_limit
//
// Per item, bit-serial steps scale the deltas, the shared rotation unit runs once
// for yaw and once for pitch, and bit-serial steps form the two cosine products;
// a new position is taken only once the result has gone to the result register.
// Reset is synchronous; it restores the register defaults and awaits a first sample.
// The result register holds while rsp_tready is low; the next position is taken
// meanwhile and the block stalls only when a new result is ready and the old one waits.

module mouse_look_orientation (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mlo_pkg::REQ_W-1:0]       req_tdata,   // x_pos, y_pos
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [mlo_pkg::RSP_W-1:0]            rsp_tdata,   // front_x, front_y,
                                                             // front_z, yaw_angle,
                                                             // pitch_angle
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mlo_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mlo_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mlo_pkg::*;

   state_type state_ff, state_in;

   logic [SENS_W-1:0]         sens_ff, sens_in;
   logic [PLIM_W-1:0]         plim_ff, plim_in;
   logic                      first_ff, first_in;
   logic [POS_W-1:0]          last_x_ff, last_x_in;
   logic [POS_W-1:0]          last_y_ff, last_y_in;
   logic [ACC_W-1:0]          yaw_ff, yaw_in;
   logic [ACC_W-1:0]          pitch_ff, pitch_in;
   logic [Q14_W-1:0]          pitch_out_ff, pitch_out_in;

   logic [IT_W-1:0]           it_ff, it_in;
   logic [SENS_W-1:0]         digit_ff, digit_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic signed [CW-1:0]      psum_ff, psum_in;

   logic signed [CW-1:0]      cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                      flip_ff, flip_in;

   logic [Q14_W-1:0]          cos_yaw_ff, cos_yaw_in, sin_yaw_ff, sin_yaw_in;
   logic [Q14_W-1:0]          cos_pitch_ff, cos_pitch_in, sin_pitch_ff, sin_pitch_in;
   logic signed [BLEND_W-1:0] bx_ff, bx_in, bz_ff, bz_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;

   logic signed [DELTA_W-1:0] x_new, y_new, x_old, y_old;
   logic signed [CW-1:0]      xs, ys, at, lim, psat;
   logic [CW:0]               folded;
   logic signed [BLEND_W-1:0] by, bs, bc, tx, tz;
   logic signed [PROD_W-1:0]  tdx, tdy;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      sens_in      = sens_ff;
      plim_in      = plim_ff;
      first_in     = first_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      pitch_out_in = pitch_out_ff;
      it_in        = it_ff;
      digit_in     = digit_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      psum_in      = psum_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      flip_in      = flip_ff;
      cos_yaw_in   = cos_yaw_ff;
      sin_yaw_in   = sin_yaw_ff;
      cos_pitch_in = cos_pitch_ff;
      sin_pitch_in = sin_pitch_ff;
      bx_in        = bx_ff;
      bz_in        = bz_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Deltas against the previous position; the first sample is its own reference
      x_new = DELTA_W'(signed'(req_tdata[POS_W-1:0]));
      y_new = DELTA_W'(signed'(req_tdata[2*POS_W-1:POS_W]));
      x_old = first_ff ? x_new : DELTA_W'(signed'(last_x_ff));
      y_old = first_ff ? y_new : DELTA_W'(signed'(last_y_ff));

      // Sensitivity digit, most significant first
      tdx = digit_ff[SENS_W-1] ? PROD_W'(dx_ff) : '0;
      tdy = digit_ff[SENS_W-1] ? PROD_W'(dy_ff) : '0;

      // One rotation step
      xs = cx_ff >>> it_ff;
      ys = cy_ff >>> it_ff;
      at = CW'(atan_lut(it_ff));

      // Pitch clamp
      lim = CW'({plim_ff, 8'h00});
      if (psum_ff > lim)
         psat = lim;
      else if (psum_ff < -lim)
         psat = -lim;
      else
         psat = psum_ff;

      folded = fold_angle(yaw_ff);

      // Cosine-of-pitch digit; the sign digit carries negative weight
      by = BLEND_W'(signed'(cos_pitch_ff));
      bc = BLEND_W'(signed'(cos_yaw_ff));
      bs = BLEND_W'(signed'(sin_yaw_ff));
      tx = by[BLEND_W-1 - it_ff] ? bc : '0;
      tz = by[BLEND_W-1 - it_ff] ? bs : '0;

      // Drop the result once taken
      if (rsp_tready)
         rsp_valid_in = 1'b0;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_SENS: sens_in = csr_data[SENS_W-1:0];
            CSR_PLIM: plim_in = csr_data[PLIM_W-1:0];
            default:  ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dx_in     = x_new - x_old;
               dy_in     = y_old - y_new;
               last_x_in = req_tdata[POS_W-1:0];
               last_y_in = req_tdata[2*POS_W-1:POS_W];
               first_in  = 1'b0;
               digit_in  = sens_ff;
               prod_x_in = '0;
               prod_y_in = '0;
               it_in     = '0;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_x_in = (prod_x_ff <<< 1) + tdx;
            prod_y_in = (prod_y_ff <<< 1) + tdy;
            digit_in  = digit_ff << 1;
            it_in     = it_ff + IT_W'(1);
            if (it_ff == IT_W'(SENS_W - 1))
               state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            yaw_in   = yaw_ff + prod_x_ff[ACC_W-1:0];
            psum_in  = CW'(signed'(pitch_ff)) + CW'(prod_y_ff);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            pitch_in     = psat[ACC_W-1:0];
            pitch_out_in = psat[Q14_W+7:8];
            flip_in      = folded[CW];
            cz_in        = folded[CW-1:0];
            cx_in        = GAIN_Q30;
            cy_in        = '0;
            it_in        = '0;
            state_in     = ST_ROT_YAW;
         end
         ST_ROT_YAW, ST_ROT_PITCH: begin
            if (!cz_ff[CW-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - at;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + at;
            end
            it_in = it_ff + IT_W'(1);
            if (it_ff == IT_W'(CORDIC_STEPS - 1))
               state_in = (state_ff == ST_ROT_YAW) ? ST_SAVE_YAW : ST_SAVE_PITCH;
         end
         ST_SAVE_YAW: begin
            cos_yaw_in = round_q30(cx_ff, flip_ff);
            sin_yaw_in = round_q30(cy_ff, flip_ff);
            folded     = fold_angle(pitch_ff);
            flip_in    = folded[CW];
            cz_in      = folded[CW-1:0];
            cx_in      = GAIN_Q30;
            cy_in      = '0;
            it_in      = '0;
            state_in   = ST_ROT_PITCH;
         end
         ST_SAVE_PITCH: begin
            cos_pitch_in = round_q30(cx_ff, flip_ff);
            sin_pitch_in = round_q30(cy_ff, flip_ff);
            bx_in        = '0;
            bz_in        = '0;
            it_in        = IT_W'(BLEND_W - Q14_W);
            state_in     = ST_BLEND;
         end
         ST_BLEND: begin
            if (it_ff == IT_W'(BLEND_W - Q14_W)) begin
               bx_in = (bx_ff <<< 1) - tx;
               bz_in = (bz_ff <<< 1) - tz;
            end else begin
               bx_in = (bx_ff <<< 1) + tx;
               bz_in = (bz_ff <<< 1) + tz;
            end
            it_in = it_ff + IT_W'(1);
            if (it_ff == IT_W'(BLEND_W - 1))
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pitch_out_ff, yaw_ff[ACC_W-1:8], round_q28(bz_ff),
                               sin_pitch_ff, round_q28(bx_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sens_ff      <= SENS_RESET;
         plim_ff      <= PLIM_RESET;
         first_ff     <= 1'b1;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         yaw_ff       <= YAW_RESET;
         pitch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         it_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         sens_ff      <= sens_in;
         plim_ff      <= plim_in;
         first_ff     <= first_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         rsp_valid_ff <= rsp_valid_in;
         it_ff        <= it_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      pitch_out_ff <= pitch_out_in;
      digit_ff     <= digit_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      prod_x_ff    <= prod_x_in;
      prod_y_ff    <= prod_y_in;
      psum_ff      <= psum_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      flip_ff      <= flip_in;
      cos_yaw_ff   <= cos_yaw_in;
      sin_yaw_ff   <= sin_yaw_in;
      cos_pitch_ff <= cos_pitch_in;
      sin_pitch_ff <= sin_pitch_in;
      bx_ff        <= bx_in;
      bz_ff        <= bz_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire
